// File: design/stb_pkg.sv
// Shared types and constants for the software timer bank.
// Used by stb_ctrl, stb_datapath and software_timer_bank; no dependencies.
`default_nettype none

package stb_pkg;

   localparam int NUM_TIMERS = 12;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int SLOT_W     = 4;
   localparam int CMD_W      = 3;
   localparam int KIND_W     = 2;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;

   // Reciprocals for amount / 10 and amount / 10000, exact over 32-bit inputs.
   localparam logic [DATA_W-1:0] MS_RECIP = 32'hCCCC_CCCD;
   localparam int                MS_SHIFT = 35;
   localparam logic [DATA_W-1:0] US_RECIP = 32'hD1B7_1759;
   localparam int                US_SHIFT = 45;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK        = 3'd0,
      CMD_ALLOC       = 3'd1,
      CMD_SET_HANDLER = 3'd2,
      CMD_ARM_MS      = 3'd3,
      CMD_ARM_US      = 3'd4,
      CMD_DISARM      = 3'd5,
      CMD_RELEASE     = 3'd6
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_OK      = 2'd0,
      KIND_REFUSED = 2'd1,
      KIND_EXPIRED = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_ARM,
      OP_SIMPLE
   } op_class_type;

   typedef struct packed {
      logic capture;
      logic do_tick;
      logic do_mul;
      logic do_arm;
      logic do_single;
      logic scan_eval;
      logic cnt_clear;
      logic cnt_inc;
      logic emit_expiry;
      logic emit_idle;
   } ctl_type;

   typedef struct packed {
      op_class_type op_class;
      logic         out_free;
      logic         cnt_at_end;
      logic         mask_empty;
      logic         mask_hit;
      logic         hit_last;
   } stat_type;

endpackage

`default_nettype wire

// File: design/stb_ctrl.sv
// Sequencing state machine for the software timer bank.
// Depends on stb_pkg; drives stb_datapath through ctl_type commands.
`default_nettype none

module stb_ctrl
   import stb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctl_type  ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_ARM,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.op_class)
               OP_TICK: begin
                  ctl.do_tick   = 1'b1;
                  ctl.cnt_clear = 1'b1;
                  state_in      = S_SCAN;
               end
               OP_ARM: begin
                  ctl.do_mul = 1'b1;
                  state_in   = S_ARM;
               end
               default: begin
                  if (stat.out_free) begin
                     ctl.do_single = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end
         S_ARM: begin
            if (stat.out_free) begin
               ctl.do_arm = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_SCAN: begin
            ctl.scan_eval = 1'b1;
            if (stat.cnt_at_end) begin
               ctl.cnt_clear = 1'b1;
               state_in      = S_EMIT;
            end else begin
               ctl.cnt_inc = 1'b1;
            end
         end
         S_EMIT: begin
            if (stat.mask_empty) begin
               if (stat.out_free) begin
                  ctl.emit_idle = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (!stat.mask_hit) begin
               ctl.cnt_inc = 1'b1;
            end else if (stat.out_free) begin
               ctl.emit_expiry = 1'b1;
               if (stat.hit_last) begin
                  state_in = S_IDLE;
               end else begin
                  ctl.cnt_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: design/stb_datapath.sv
// Slot storage, tick counter, tick conversion and result register.
// Depends on stb_pkg; sequenced by stb_ctrl.
`default_nettype none

module stb_datapath
   import stb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   output stat_type           stat,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [SLOT_W-1:0]  req_timer_index,
   input  logic [DATA_W-1:0]  req_amount,
   input  logic               req_periodic,
   input  logic               req_handler_present,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [DATA_W-1:0]  rsp_cookie,
   output logic               rsp_last
);

   // captured item
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [DATA_W-1:0] amount_ff, amount_in;
   logic              per_ff, per_in;
   logic              present_ff, present_in;

   // timer state
   logic [DATA_W-1:0]     tick_ff, tick_in;
   logic [NUM_TIMERS-1:0] used_ff, used_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in;
   logic [NUM_TIMERS-1:0] periodic_ff, periodic_in;
   logic [NUM_TIMERS-1:0] handler_ff, handler_in;
   logic [DATA_W-1:0]     period_ff [NUM_TIMERS];
   logic [DATA_W-1:0]     period_in [NUM_TIMERS];
   logic [DATA_W-1:0]     due_ff    [NUM_TIMERS];
   logic [DATA_W-1:0]     due_in    [NUM_TIMERS];
   logic [DATA_W-1:0]     cookie_ff [NUM_TIMERS];
   logic [DATA_W-1:0]     cookie_in [NUM_TIMERS];

   // scan and conversion
   logic [NUM_TIMERS-1:0] mask_ff, mask_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [DATA_W-1:0] rsp_cookie_ff, rsp_cookie_in;
   logic              rsp_last_ff, rsp_last_in;

   logic                  idx_ok;
   logic [IDX_W-1:0]      idx_sel;
   logic                  free_found;
   logic [IDX_W-1:0]      free_idx;
   logic [DATA_W-1:0]     recip;
   logic [DATA_W-1:0]     quot;
   logic [DATA_W-1:0]     ticks;
   logic [DATA_W-1:0]     elapsed;
   logic                  slot_live;
   logic [NUM_TIMERS-1:0] mask_upper;
   logic                  out_free;
   logic                  load;

   assign idx_ok  = {1'b0, idx_ff} < (SLOT_W + 1)'(NUM_TIMERS);
   assign idx_sel = idx_ff[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   assign recip = (cmd_ff == CMD_ARM_MS) ? MS_RECIP : US_RECIP;
   assign quot  = (cmd_ff == CMD_ARM_MS) ? DATA_W'(prod_ff >> MS_SHIFT)
                                         : DATA_W'(prod_ff >> US_SHIFT);
   assign ticks = (quot == '0) ? DATA_W'(1) : quot;

   assign elapsed    = tick_ff - due_ff[cnt_ff];
   assign slot_live  = used_ff[cnt_ff] && armed_ff[cnt_ff] && handler_ff[cnt_ff];
   assign mask_upper = mask_ff >> cnt_ff;

   always_comb begin
      stat.op_class = OP_SIMPLE;
      case (cmd_ff)
         CMD_TICK: stat.op_class = OP_TICK;
         CMD_ARM_MS, CMD_ARM_US: stat.op_class = idx_ok ? OP_ARM : OP_SIMPLE;
         default: stat.op_class = OP_SIMPLE;
      endcase
      stat.out_free   = out_free;
      stat.cnt_at_end = cnt_ff == IDX_W'(NUM_TIMERS - 1);
      stat.mask_empty = mask_ff == '0;
      stat.mask_hit   = mask_ff[cnt_ff];
      stat.hit_last   = (mask_upper >> 1) == '0;
   end

   always_comb begin
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      amount_in     = amount_ff;
      per_in        = per_ff;
      present_in    = present_ff;
      tick_in       = tick_ff;
      used_in       = used_ff;
      armed_in      = armed_ff;
      periodic_in   = periodic_ff;
      handler_in    = handler_ff;
      period_in     = period_ff;
      due_in        = due_ff;
      cookie_in     = cookie_ff;
      mask_in       = mask_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_cookie_in = rsp_cookie_ff;
      rsp_last_in   = rsp_last_ff;
      load          = 1'b0;

      if (ctl.capture) begin
         cmd_in     = req_command;
         idx_in     = req_timer_index;
         amount_in  = req_amount;
         per_in     = req_periodic;
         present_in = req_handler_present;
      end

      if (ctl.do_tick) begin
         tick_in = tick_ff + DATA_W'(1);
         mask_in = '0;
      end

      if (ctl.do_mul) begin
         prod_in = PROD_W'(amount_ff) * PROD_W'(recip);
      end

      if (ctl.do_arm) begin
         period_in[idx_sel]   = ticks;
         due_in[idx_sel]      = tick_ff + ticks;
         periodic_in[idx_sel] = per_ff;
         armed_in[idx_sel]    = 1'b1;
         load                 = 1'b1;
         rsp_kind_in          = KIND_OK;
         rsp_slot_in          = idx_ff;
         rsp_cookie_in        = '0;
         rsp_last_in          = 1'b1;
      end

      if (ctl.do_single) begin
         load          = 1'b1;
         rsp_kind_in   = KIND_OK;
         rsp_slot_in   = idx_ff;
         rsp_cookie_in = '0;
         rsp_last_in   = 1'b1;
         if (cmd_ff == CMD_ALLOC) begin
            if (free_found) begin
               used_in[free_idx]    = 1'b1;
               armed_in[free_idx]   = 1'b0;
               handler_in[free_idx] = 1'b0;
               rsp_slot_in          = SLOT_W'(free_idx);
            end else begin
               rsp_kind_in = KIND_REFUSED;
               rsp_slot_in = '0;
            end
         end else if (!idx_ok) begin
            rsp_kind_in = KIND_REFUSED;
         end else begin
            case (cmd_ff)
               CMD_SET_HANDLER: begin
                  handler_in[idx_sel] = present_ff;
                  cookie_in[idx_sel]  = amount_ff;
               end
               CMD_DISARM: begin
                  armed_in[idx_sel] = 1'b0;
               end
               CMD_RELEASE: begin
                  armed_in[idx_sel]   = 1'b0;
                  used_in[idx_sel]    = 1'b0;
                  handler_in[idx_sel] = 1'b0;
               end
               default: begin
                  rsp_kind_in = KIND_REFUSED;
               end
            endcase
         end
      end

      if (ctl.scan_eval && slot_live && !elapsed[DATA_W-1]) begin
         mask_in[cnt_ff] = 1'b1;
         if (periodic_ff[cnt_ff]) begin
            due_in[cnt_ff] = tick_ff + period_ff[cnt_ff];
         end else begin
            armed_in[cnt_ff] = 1'b0;
         end
      end

      if (ctl.emit_expiry) begin
         load          = 1'b1;
         rsp_kind_in   = KIND_EXPIRED;
         rsp_slot_in   = SLOT_W'(cnt_ff);
         rsp_cookie_in = cookie_ff[cnt_ff];
         rsp_last_in   = stat.hit_last;
      end

      if (ctl.emit_idle) begin
         load          = 1'b1;
         rsp_kind_in   = KIND_OK;
         rsp_slot_in   = '0;
         rsp_cookie_in = '0;
         rsp_last_in   = 1'b1;
      end

      if (ctl.cnt_clear) begin
         cnt_in = '0;
      end else if (ctl.cnt_inc) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         used_ff      <= '0;
         armed_ff     <= '0;
         periodic_ff  <= '0;
         handler_ff   <= '0;
         mask_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff      <= tick_in;
         used_ff      <= used_in;
         armed_ff     <= armed_in;
         periodic_ff  <= periodic_in;
         handler_ff   <= handler_in;
         mask_ff      <= mask_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      amount_ff     <= amount_in;
      per_ff        <= per_in;
      present_ff    <= present_in;
      period_ff     <= period_in;
      due_ff        <= due_in;
      cookie_ff     <= cookie_in;
      prod_ff       <= prod_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_cookie_ff <= rsp_cookie_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_kind   = rsp_kind_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_cookie = rsp_cookie_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// File: design/software_timer_bank.sv
// Software timer bank: one item per command, results on the rsp_ channel.
// Allocate, set handler, disarm, release and refusals give their result from the
// decode state; arm adds one registered multiply stage before its result.
// Tick: a scan over every slot, then an emit pass over the hits, one slot per
// cycle through the shared slot read port, the emit pass holding while the result register is full; one item in flight.
// Synchronous reset clears the tick count, all slot flags and the result valid.
`default_nettype none

module software_timer_bank
   import stb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [SLOT_W-1:0]  req_timer_index,
   input  logic [DATA_W-1:0]  req_amount,
   input  logic               req_periodic,
   input  logic               req_handler_present,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [KIND_W-1:0]  rsp_kind,
   output logic [SLOT_W-1:0]  rsp_slot,
   output logic [DATA_W-1:0]  rsp_cookie,
   output logic               rsp_last
);

   ctl_type  ctl;
   stat_type stat;

   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   stb_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl                 (ctl),
      .stat                (stat),
      .req_command         (req_command),
      .req_timer_index     (req_timer_index),
      .req_amount          (req_amount),
      .req_periodic        (req_periodic),
      .req_handler_present (req_handler_present),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_slot            (rsp_slot),
      .rsp_cookie          (rsp_cookie),
      .rsp_last            (rsp_last)
   );

   // one item at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while another is in progress");

   a_single_result_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != KIND_EXPIRED) |-> rsp_last)
      else $error("non-expiry result without last");

   a_expired_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_EXPIRED) |->
         ({1'b0, rsp_slot} < (SLOT_W + 1)'(NUM_TIMERS)))
      else $error("expiry reported for a slot beyond the bank");

   a_no_accept_before_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("ready raised before the final result of an item");

endmodule

`default_nettype wire

// File: sim/timer_bank_checker.sv
// Result checker for the software timer bank: tracks the slot state from the
// accepted req_ items and compares every accepted rsp_ item in order.
// Depends on stb_pkg for widths, NUM_TIMERS, command and result kinds.

module timer_bank_checker
   import stb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [SLOT_W-1:0]  req_timer_index,
   input  logic [DATA_W-1:0]  req_amount,
   input  logic               req_periodic,
   input  logic               req_handler_present,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [KIND_W-1:0]  rsp_kind,
   input  logic [SLOT_W-1:0]  rsp_slot,
   input  logic [DATA_W-1:0]  rsp_cookie,
   input  logic               rsp_last,
   output int unsigned        fail_count,
   output int unsigned        pending_count
);

   localparam logic [DATA_W-1:0] MS_PER_TICK = 32'd10;
   localparam logic [DATA_W-1:0] US_PER_TICK = 32'd10000;

   typedef struct packed {
      kind_type              kind;
      logic [SLOT_W-1:0]     slot;
      logic [DATA_W-1:0]     cookie;
      logic                  last;
   } timer_event_type;

   timer_event_type   timer_events[$];
   logic [DATA_W-1:0] tick_count;
   logic              slot_used        [NUM_TIMERS];
   logic              slot_armed       [NUM_TIMERS];
   logic              slot_periodic    [NUM_TIMERS];
   logic              slot_has_handler [NUM_TIMERS];
   logic [DATA_W-1:0] slot_period      [NUM_TIMERS];
   logic [DATA_W-1:0] slot_due         [NUM_TIMERS];
   logic [DATA_W-1:0] slot_cookie      [NUM_TIMERS];

   function automatic void push_event(input kind_type kind, input logic [SLOT_W-1:0] slot,
                                      input logic [DATA_W-1:0] cookie, input logic last);
      timer_event_type ev;
      ev.kind   = kind;
      ev.slot   = slot;
      ev.cookie = cookie;
      ev.last   = last;
      timer_events.push_back(ev);
   endfunction

   task automatic clear_bank();
      int i;
      tick_count = '0;
      for (i = 0; i < NUM_TIMERS; i++) begin
         slot_used[i]        = 1'b0;
         slot_armed[i]       = 1'b0;
         slot_periodic[i]    = 1'b0;
         slot_has_handler[i] = 1'b0;
         slot_period[i]      = '0;
         slot_due[i]         = '0;
         slot_cookie[i]      = '0;
      end
      timer_events.delete();
   endtask

   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] idx,
                                input logic [DATA_W-1:0] amount, input logic per,
                                input logic present);
      int              i;
      int              fired;
      bit              found;
      logic [DATA_W-1:0] lag;
      logic [DATA_W-1:0] ticks;
      timer_event_type ev;
      case (cmd)
         CMD_TICK: begin
            tick_count = tick_count + 1'b1;
            fired = 0;
            for (i = 0; i < NUM_TIMERS; i++) begin
               if (slot_used[i] && slot_armed[i] && slot_has_handler[i]) begin
                  lag = tick_count - slot_due[i];
                  if (!lag[DATA_W-1]) begin
                     if (slot_periodic[i]) slot_due[i] = tick_count + slot_period[i];
                     else slot_armed[i] = 1'b0;
                     push_event(KIND_EXPIRED, SLOT_W'(i), slot_cookie[i], 1'b0);
                     fired++;
                  end
               end
            end
            if (fired == 0) begin
               push_event(KIND_OK, '0, '0, 1'b1);
            end else begin
               ev = timer_events.pop_back();
               ev.last = 1'b1;
               timer_events.push_back(ev);
            end
         end
         CMD_ALLOC: begin
            found = 1'b0;
            for (i = 0; i < NUM_TIMERS; i++) begin
               if (!found && !slot_used[i]) begin
                  found               = 1'b1;
                  slot_used[i]        = 1'b1;
                  slot_armed[i]       = 1'b0;
                  slot_has_handler[i] = 1'b0;
                  push_event(KIND_OK, SLOT_W'(i), '0, 1'b1);
               end
            end
            if (!found) push_event(KIND_REFUSED, '0, '0, 1'b1);
         end
         CMD_SET_HANDLER, CMD_ARM_MS, CMD_ARM_US, CMD_DISARM, CMD_RELEASE: begin
            if (idx >= NUM_TIMERS) begin
               push_event(KIND_REFUSED, idx, '0, 1'b1);
            end else begin
               case (cmd)
                  CMD_SET_HANDLER: begin
                     slot_has_handler[idx] = present;
                     slot_cookie[idx]      = amount;
                  end
                  CMD_ARM_MS, CMD_ARM_US: begin
                     ticks = (cmd == CMD_ARM_MS) ? amount / MS_PER_TICK : amount / US_PER_TICK;
                     if (ticks == '0) ticks = 1;
                     slot_period[idx]   = ticks;
                     slot_due[idx]      = tick_count + ticks;
                     slot_periodic[idx] = per;
                     slot_armed[idx]    = 1'b1;
                  end
                  CMD_DISARM: begin
                     slot_armed[idx] = 1'b0;
                  end
                  default: begin
                     slot_armed[idx]       = 1'b0;
                     slot_used[idx]        = 1'b0;
                     slot_has_handler[idx] = 1'b0;
                  end
               endcase
               push_event(KIND_OK, idx, '0, 1'b1);
            end
         end
         default: begin
            push_event(KIND_REFUSED, idx, '0, 1'b1);
         end
      endcase
   endtask

   task automatic check_result();
      timer_event_type want;
      if (timer_events.size() == 0) begin
         $error("unexpected item: kind %0d slot %0d cookie %h last %0d",
                rsp_kind, rsp_slot, rsp_cookie, rsp_last);
         fail_count++;
      end else begin
         want = timer_events.pop_front();
         if (rsp_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
            fail_count++;
         end
         if (rsp_slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, rsp_slot);
            fail_count++;
         end
         if (rsp_cookie !== want.cookie) begin
            $error("cookie: expected %h, actual %h", want.cookie, rsp_cookie);
            fail_count++;
         end
         if (rsp_last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, rsp_last);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_bank();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready)
            apply_command(req_command, req_timer_index, req_amount, req_periodic,
                          req_handler_present);
         if (rsp_valid && rsp_ready) check_result();
      end
      pending_count <= timer_events.size();
   end

endmodule

// File: sim/testbench.sv
// Top of the software timer bank simulation: clock, reset, command stimulus,
// response back-pressure and the verdict. Depends on stb_pkg,
// software_timer_bank and timer_bank_checker.

module testbench;
   import stb_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNDEFINED = 3'd7;
   localparam int RANDOM_ITEMS   = 120;
   localparam int DIRECTED_ITEMS = 24;
   localparam int FILL_ITEMS     = 3 * NUM_TIMERS + 2;
   localparam int LOOP_ITEMS     = RANDOM_ITEMS - FILL_ITEMS - DIRECTED_ITEMS;
   localparam int HOLD_CYCLES    = 150;

   logic               clock;
   logic               reset               = 1'b1;
   logic               req_valid           = 1'b0;
   logic               req_ready;
   logic [CMD_W-1:0]   req_command         = '0;
   logic [SLOT_W-1:0]  req_timer_index     = '0;
   logic [DATA_W-1:0]  req_amount          = '0;
   logic               req_periodic        = 1'b0;
   logic               req_handler_present = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready           = 1'b1;
   logic [KIND_W-1:0]  rsp_kind;
   logic [SLOT_W-1:0]  rsp_slot;
   logic [DATA_W-1:0]  rsp_cookie;
   logic               rsp_last;
   int unsigned        fail_count;
   int unsigned        pending_count;
   int                 items_sent = 0;
   bit                 quiet      = 1'b0;

   software_timer_bank DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_timer_index     (req_timer_index),
      .req_amount          (req_amount),
      .req_periodic        (req_periodic),
      .req_handler_present (req_handler_present),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_slot            (rsp_slot),
      .rsp_cookie          (rsp_cookie),
      .rsp_last            (rsp_last)
   );

   timer_bank_checker u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] idx,
                            input logic [DATA_W-1:0] amount, input logic per,
                            input logic present);
      int gap;
      gap = 0;
      if (!quiet && (items_sent % 32) >= 10 && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_timer_index     <= idx;
      req_amount          <= amount;
      req_periodic        <= per;
      req_handler_present <= present;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [SLOT_W-1:0] pick_index();
      if ($urandom_range(0, 7) == 0) return SLOT_W'($urandom_range(NUM_TIMERS, 15));
      return SLOT_W'($urandom_range(0, NUM_TIMERS - 1));
   endfunction

   // mostly short periods so armed slots actually fire
   function automatic logic [DATA_W-1:0] pick_arm_amount(input logic [CMD_W-1:0] cmd);
      if ($urandom_range(0, 5) == 0) return $urandom;
      if (cmd == CMD_ARM_MS) return $urandom_range(0, 59);
      return $urandom_range(0, 59999);
   endfunction

   // response side: one long hold to back the block up, plus short random stalls
   initial begin
      bit held;
      int beat;
      held = 1'b0;
      beat = 0;
      forever begin
         @(posedge clock);
         beat++;
         if (!held && items_sent >= 40) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && (beat % 100) >= 30 && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int                n;
      int                s;
      int                roll;
      int                wait_cycles;
      logic [CMD_W-1:0]  cmd;
      logic [SLOT_W-1:0] idx;
      logic [DATA_W-1:0] word;
      logic              per;
      logic              present;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed
      send_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
      send_item(CMD_SET_HANDLER, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(CMD_ARM_MS, 4'(NUM_TIMERS), 32'd100, 1'b1, 1'b0);
      send_item(CMD_UNDEFINED, 4'd5, 32'd0, 1'b0, 1'b0);
      // unallocated slot takes handler and arm but never fires
      send_item(CMD_SET_HANDLER, 4'd3, 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_item(CMD_ARM_MS, 4'd3, 32'd0, 1'b0, 1'b0);
      send_item(CMD_TICK, 4'd9, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(CMD_ALLOC, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_item(CMD_ALLOC, 4'd0, 32'd0, 1'b0, 1'b0);
      send_item(CMD_SET_HANDLER, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
      send_item(CMD_SET_HANDLER, 4'd1, 32'h1234_5678, 1'b0, 1'b0);
      send_item(CMD_ARM_MS, 4'd0, 32'd9, 1'b1, 1'b0);
      send_item(CMD_ARM_US, 4'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
      send_item(CMD_SET_HANDLER, 4'd1, 32'd0, 1'b0, 1'b1);
      send_item(CMD_ARM_US, 4'd1, 32'd19999, 1'b0, 1'b0);
      send_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
      send_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
      send_item(CMD_DISARM, 4'd0, 32'd0, 1'b0, 1'b0);
      send_item(CMD_TICK, 4'd0, 32'd0, 1'b0, 1'b0);
      send_item(CMD_RELEASE, 4'd1, 32'd0, 1'b0, 1'b0);
      send_item(CMD_ARM_MS, 4'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
      send_item(CMD_RELEASE, 4'd15, 32'd0, 1'b0, 1'b0);
      send_item(CMD_ALLOC, 4'd0, 32'd0, 1'b0, 1'b0);

      // fill the bank, install handlers, arm every slot for one tick, fire
      repeat (NUM_TIMERS + 1) send_item(CMD_ALLOC, SLOT_W'($urandom_range(0, 15)), $urandom,
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (s = 0; s < NUM_TIMERS; s++)
         send_item(CMD_SET_HANDLER, SLOT_W'(s), $urandom, 1'($urandom_range(0, 1)), 1'b1);
      for (s = 0; s < NUM_TIMERS; s++) begin
         cmd = $urandom_range(0, 1) ? CMD_ARM_MS : CMD_ARM_US;
         word = (cmd == CMD_ARM_MS) ? $urandom_range(0, 19) : $urandom_range(0, 19999);
         send_item(cmd, SLOT_W'(s), word, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      send_item(CMD_TICK, pick_index(), $urandom, 1'b0, 1'b0);

      for (n = 0; n < LOOP_ITEMS; n++) begin
         if (n >= LOOP_ITEMS - 20) quiet = 1'b1;
         roll    = $urandom_range(0, 99);
         idx     = pick_index();
         word    = $urandom;
         per     = 1'($urandom_range(0, 1));
         present = 1'($urandom_range(0, 1));
         if (roll < 28) begin
            send_item(CMD_TICK, idx, word, per, present);
         end else if (roll < 40) begin
            send_item(CMD_ALLOC, idx, word, per, present);
         end else if (roll < 55) begin
            send_item(CMD_SET_HANDLER, idx, word, per, $urandom_range(0, 3) != 0);
         end else if (roll < 78) begin
            cmd = $urandom_range(0, 1) ? CMD_ARM_MS : CMD_ARM_US;
            send_item(cmd, idx, pick_arm_amount(cmd), per, present);
         end else if (roll < 86) begin
            send_item(CMD_DISARM, idx, word, per, present);
         end else if (roll < 92) begin
            send_item(CMD_RELEASE, idx, word, per, present);
         end else if (roll < 95) begin
            send_item(CMD_UNDEFINED, idx, word, per, present);
         end else begin
            send_item(CMD_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 15)), word,
                      per, present);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      for (wait_cycles = 0; wait_cycles < 2000 && pending_count != 0; wait_cycles++)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (pending_count != 0) $error("%0d expected items never arrived", pending_count);
      if (fail_count == 0 && pending_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
design/stb_pkg.sv
design/stb_ctrl.sv
design/stb_datapath.sv
design/software_timer_bank.sv
sim/timer_bank_checker.sv
sim/testbench.sv
